FILE: design/tksl_pkg.sv
// Shared types and constants for the top-k score list.
package tksl_pkg;

    localparam int OPC_W   = 2;
    localparam int SCORE_W = 32;
    localparam int TAG_W   = 16;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;

    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic [TAG_W-1:0]          tag_t;

    localparam score_t SCORE_MIN = 32'sh8000_0000;

    localparam logic [OPC_W-1:0] OP_INSERT    = 2'd0;
    localparam logic [OPC_W-1:0] OP_OVERWRITE = 2'd1;
    localparam logic [OPC_W-1:0] OP_CLEAR     = 2'd2;

    // Command kinds after the front end has folded in the mode bit
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_SORTED,
        CMD_APPEND,
        CMD_OVERWRITE,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        score_t            score;
        tag_t              tag;
        logic [SLOT_W-1:0] slot;
    } cmd_t;

    typedef struct packed {
        score_t score;
        tag_t   tag;
    } entry_t;

endpackage

FILE: design/tksl_if.sv
// Valid/ready channel interfaces for request and result items.
interface tksl_in_if
    import tksl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OPC_W-1:0]   opcode;
    score_t             new_score;
    tag_t               new_tag;
    logic [SLOT_W-1:0]  slot_index;

    modport source (output valid, opcode, new_score, new_tag, slot_index, input ready);
    modport sink   (input valid, opcode, new_score, new_tag, slot_index, output ready);
endinterface

interface tksl_out_if
    import tksl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               accepted;
    logic               evicted_valid;
    tag_t               evicted_tag;
    logic [COUNT_W-1:0] entry_count;
    logic               best_valid;
    tag_t               best_tag;
    score_t             best_score;

    modport source (output valid, accepted, evicted_valid, evicted_tag, entry_count,
                    best_valid, best_tag, best_score, input ready);
    modport sink   (input valid, accepted, evicted_valid, evicted_tag, entry_count,
                    best_valid, best_tag, best_score, output ready);
endinterface

FILE: design/tksl_front.sv
// Front end: takes request items and classifies them into commands.
module tksl_front
    import tksl_pkg::*;
(
    input  logic       sorted_mode,
    tksl_in_if.sink    req,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_data
);

    assign req.ready = !q_full;
    assign q_push    = req.valid && !q_full;

    always_comb
    begin
        q_data.score = req.new_score;
        q_data.tag   = req.new_tag;
        q_data.slot  = req.slot_index;
        case (req.opcode)
            OP_INSERT:    q_data.kind = sorted_mode ? CMD_SORTED : CMD_APPEND;
            OP_OVERWRITE: q_data.kind = CMD_OVERWRITE;
            OP_CLEAR:     q_data.kind = CMD_CLEAR;
            default:      q_data.kind = CMD_NOP;
        endcase
    end

endmodule

FILE: design/tksl_cmd_fifo.sv
// Two-entry command queue between the front end and the list engine.
module tksl_cmd_fifo
    import tksl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/tksl_back.sv
// List engine: slot memory, insert/shift sequencer, best-entry scan, result register.
module tksl_back
    import tksl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    tksl_out_if.source  rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;
    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [IW-1:0] LAST_C = IW'(CAPACITY - 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_EVICT    = 7'b0000010,
        S_OVR      = 7'b0000100,
        S_WALK_RD  = 7'b0001000,
        S_WALK_CMP = 7'b0010000,
        S_SCAN     = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    score_t          floor_reg, floor_next;
    cmd_t            cur_reg, cur_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   scan_reg, scan_next;
    logic            pend_reg, pend_next;
    logic            pend_last_reg, pend_last_next;
    logic            acc_reg, acc_next;
    logic            ev_valid_reg, ev_valid_next;
    tag_t            ev_tag_reg, ev_tag_next;
    logic            best_valid_reg, best_valid_next;
    tag_t            best_tag_reg, best_tag_next;
    score_t          best_score_reg, best_score_next;

    logic               rsp_valid_reg;
    logic               rsp_acc_reg;
    logic               rsp_ev_valid_reg;
    tag_t               rsp_ev_tag_reg;
    logic [COUNT_W-1:0] rsp_count_reg;
    logic               rsp_best_valid_reg;
    tag_t               rsp_best_tag_reg;
    score_t             rsp_best_score_reg;
    logic               out_load;

    entry_t          mem [CAPACITY];
    entry_t          rd_reg;
    logic            mem_we, mem_re;
    logic [IW-1:0]   mem_waddr, mem_raddr;
    entry_t          mem_wdata;

    logic [XW-1:0]   slot_x, count_x;

    assign slot_x  = XW'(cmd.slot);
    assign count_x = XW'(count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        floor_next      = floor_reg;
        cur_next        = cur_reg;
        idx_next        = idx_reg;
        scan_next       = scan_reg;
        pend_next       = 1'b0;
        pend_last_next  = 1'b0;
        acc_next        = acc_reg;
        ev_valid_next   = ev_valid_reg;
        ev_tag_next     = ev_tag_reg;
        best_valid_next = best_valid_reg;
        best_tag_next   = best_tag_reg;
        best_score_next = best_score_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = '{score: cur_reg.score, tag: cur_reg.tag};
        mem_re          = 1'b0;
        mem_raddr       = idx_reg;
        cmd_pop         = 1'b0;
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop         = 1'b1;
                    cur_next        = cmd;
                    acc_next        = 1'b0;
                    ev_valid_next   = 1'b0;
                    ev_tag_next     = '0;
                    best_valid_next = 1'b0;
                    best_tag_next   = '0;
                    best_score_next = SCORE_MIN;
                    scan_next       = '0;
                    state_next      = S_SCAN;
                    mem_wdata       = '{score: cmd.score, tag: cmd.tag};
                    case (cmd.kind)
                        CMD_SORTED:
                        begin
                            if (count_reg == '0)
                            begin
                                // empty list takes anything, floor or not
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                count_next = CW'(1);
                                acc_next   = 1'b1;
                            end
                            else if ($signed(cmd.score) >= $signed(floor_reg))
                            begin
                                acc_next = 1'b1;
                                if (count_reg < CAP_C)
                                begin
                                    idx_next   = IW'(count_reg);
                                    count_next = count_reg + CW'(1);
                                    state_next = S_WALK_RD;
                                end
                                else
                                begin
                                    // full: fetch the worst entry's tag before replacing it
                                    idx_next   = LAST_C;
                                    mem_re     = 1'b1;
                                    mem_raddr  = LAST_C;
                                    state_next = S_EVICT;
                                end
                            end
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg < CAP_C)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = IW'(count_reg);
                                count_next = count_reg + CW'(1);
                                acc_next   = 1'b1;
                            end
                        end
                        CMD_OVERWRITE:
                        begin
                            if (slot_x < count_x)
                            begin
                                idx_next   = IW'(slot_x);
                                mem_re     = 1'b1;
                                mem_raddr  = IW'(slot_x);
                                state_next = S_OVR;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            floor_next = SCORE_MIN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_EVICT:
            begin
                ev_valid_next = 1'b1;
                ev_tag_next   = rd_reg.tag;
                state_next    = S_WALK_RD;
            end
            S_OVR:
            begin
                ev_valid_next = 1'b1;
                ev_tag_next   = rd_reg.tag;
                acc_next      = 1'b1;
                mem_we        = 1'b1;
                state_next    = S_SCAN;
            end
            S_WALK_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg - IW'(1);
                    state_next = S_WALK_CMP;
                end
            end
            S_WALK_CMP:
            begin
                mem_we = 1'b1;
                // ties move down too: the newcomer passes equal scores
                if ($signed(rd_reg.score) <= $signed(cur_reg.score))
                begin
                    mem_wdata  = rd_reg;
                    idx_next   = idx_reg - IW'(1);
                    state_next = S_WALK_RD;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_reg < count_reg)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = IW'(scan_reg);
                    scan_next      = scan_reg + CW'(1);
                    pend_next      = 1'b1;
                    pend_last_next = (scan_reg == count_reg - CW'(1));
                end
                else if (!pend_reg)
                begin
                    state_next = S_DONE;
                end
                if (pend_reg)
                begin
                    if ($signed(rd_reg.score) > $signed(best_score_reg))
                    begin
                        best_valid_next = 1'b1;
                        best_tag_next   = rd_reg.tag;
                        best_score_next = rd_reg.score;
                    end
                    // full after a sorted insert: floor follows the last entry
                    if (pend_last_reg && cur_reg.kind == CMD_SORTED && count_reg == CAP_C)
                    begin
                        floor_next = rd_reg.score;
                    end
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            floor_reg     <= SCORE_MIN;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            floor_reg <= floor_next;
            pend_reg  <= pend_next;
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        idx_reg        <= idx_next;
        scan_reg       <= scan_next;
        pend_last_reg  <= pend_last_next;
        acc_reg        <= acc_next;
        ev_valid_reg   <= ev_valid_next;
        ev_tag_reg     <= ev_tag_next;
        best_valid_reg <= best_valid_next;
        best_tag_reg   <= best_tag_next;
        best_score_reg <= best_score_next;
        if (out_load)
        begin
            rsp_acc_reg        <= acc_reg;
            rsp_ev_valid_reg   <= ev_valid_reg;
            rsp_ev_tag_reg     <= ev_tag_reg;
            rsp_count_reg      <= COUNT_W'(count_reg);
            rsp_best_valid_reg <= best_valid_reg;
            rsp_best_tag_reg   <= best_tag_reg;
            rsp_best_score_reg <= best_score_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_reg <= mem[mem_raddr];
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.accepted      = rsp_acc_reg;
    assign rsp.evicted_valid = rsp_ev_valid_reg;
    assign rsp.evicted_tag   = rsp_ev_tag_reg;
    assign rsp.entry_count   = rsp_count_reg;
    assign rsp.best_valid    = rsp_best_valid_reg;
    assign rsp.best_tag      = rsp_best_tag_reg;
    assign rsp.best_score    = rsp_best_score_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_evict_means_taken: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_ev_valid_reg |-> rsp_acc_reg)
        else $error("eviction reported without acceptance");

    a_best_above_min: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_best_valid_reg |-> rsp_best_score_reg != SCORE_MIN)
        else $error("best entry flagged at the lowest score");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && cmd.kind == CMD_CLEAR |=> count_reg == '0 && floor_reg == SCORE_MIN)
        else $error("clear left entries or floor behind");

    a_walk_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK_CMP |-> CW'(idx_reg) < count_reg)
        else $error("shift walk outside the held entries");

endmodule

FILE: design/top_k_score_list_core.sv
// Top level of the top-k score list: mode register, front end, queue, list engine.
//
//   channel   dir  handshake          payload
//   req       in   valid/ready        opcode, new_score, new_tag, slot_index
//   rsp       out  valid/ready        accepted, evicted_*, entry_count, best_*
//   cfg       in   cfg_wr_en strobe   cfg_wr_data -> sorted_mode
//
// One item is worked at a time by the engine over its single-port slot memory: a
// scan then reads the held entries for the best one, one slot a cycle. A sorted insert
// first walks up the list, a read and a compare for each entry it moves past; a
// full-list eviction or an overwrite first reads the slot it replaces. Reset empties
// the list and sets sorted mode; slot contents need no clearing.
// A two-entry queue keeps taking items while the result register waits on rsp.
module top_k_score_list_core
    import tksl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    tksl_in_if.sink     req,
    tksl_out_if.source  rsp
);

    logic sorted_mode_reg;
    logic q_push, q_full, q_pop, q_not_empty;
    cmd_t q_data, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sorted_mode_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            sorted_mode_reg <= cfg_wr_data;
        end
    end

    tksl_front u_front (
        .sorted_mode (sorted_mode_reg),
        .req         (req),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_data)
    );

    tksl_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    tksl_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_not_empty),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .rsp       (rsp)
    );

endmodule

FILE: tb/sv/tb_top_k_score_list_core.sv
// Self-checking testbench for top_k_score_list_core: mirrored list model plus random stimulus.
module tb_top_k_score_list_core;
    import tksl_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 160;
    localparam logic [OPC_W-1:0] OP_RESERVED = 2'd3;

    typedef struct {
        logic               accepted;
        logic               evicted_valid;
        tag_t               evicted_tag;
        logic [COUNT_W-1:0] entry_count;
        logic               best_valid;
        tag_t               best_tag;
        score_t             best_score;
    } list_result_t;

    // Mirror of the list contents; predicts one result per request item taken.
    class score_list_mirror;
        bit           sorted = 1'b1;
        score_t       slot_score[LIST_DEPTH];
        tag_t         slot_tag[LIST_DEPTH];
        int           held_count = 0;
        score_t       floor_score = SCORE_MIN;
        int           errors = 0;
        list_result_t due_results[$];

        function int pending();
            return due_results.size();
        endfunction

        function void apply_request(logic [OPC_W-1:0] op, score_t score, tag_t tag,
                                    logic [SLOT_W-1:0] slot);
            list_result_t r;
            int           i;
            score_t       s;
            tag_t         t;
            r = '{default: '0};
            r.best_score = SCORE_MIN;
            case (op)
                OP_INSERT:
                    if (sorted)
                    begin
                        if (held_count == 0)
                        begin
                            slot_score[0] = score;
                            slot_tag[0]   = tag;
                            held_count    = 1;
                            r.accepted    = 1'b1;
                        end
                        else if (score >= floor_score)
                        begin
                            if (held_count < LIST_DEPTH)
                            begin
                                slot_score[held_count] = score;
                                slot_tag[held_count]   = tag;
                                held_count++;
                            end
                            else
                            begin
                                r.evicted_valid = 1'b1;
                                r.evicted_tag   = slot_tag[held_count-1];
                                slot_score[held_count-1] = score;
                                slot_tag[held_count-1]   = tag;
                            end
                            // ties move up: the newest of equal scores ends first
                            i = held_count - 1;
                            while (i > 0 && slot_score[i] >= slot_score[i-1])
                            begin
                                s = slot_score[i];
                                t = slot_tag[i];
                                slot_score[i]   = slot_score[i-1];
                                slot_tag[i]     = slot_tag[i-1];
                                slot_score[i-1] = s;
                                slot_tag[i-1]   = t;
                                i--;
                            end
                            r.accepted = 1'b1;
                        end
                        if (held_count >= LIST_DEPTH)
                            floor_score = slot_score[held_count-1];
                    end
                    else if (held_count < LIST_DEPTH)
                    begin
                        slot_score[held_count] = score;
                        slot_tag[held_count]   = tag;
                        held_count++;
                        r.accepted = 1'b1;
                    end
                OP_OVERWRITE:
                    if (slot < held_count)
                    begin
                        r.evicted_valid  = 1'b1;
                        r.evicted_tag    = slot_tag[slot];
                        slot_score[slot] = score;
                        slot_tag[slot]   = tag;
                        r.accepted       = 1'b1;
                    end
                OP_CLEAR:
                begin
                    held_count  = 0;
                    floor_score = SCORE_MIN;
                end
                default: ;
            endcase
            for (i = 0; i < held_count; i++)
            begin
                if (slot_score[i] > r.best_score)
                begin
                    r.best_score = slot_score[i];
                    r.best_tag   = slot_tag[i];
                    r.best_valid = 1'b1;
                end
            end
            r.entry_count = COUNT_W'(held_count);
            due_results.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void compare_result(list_result_t got);
            list_result_t want;
            if (due_results.size() == 0)
            begin
                $error("result item with no request outstanding");
                errors++;
                return;
            end
            want = due_results.pop_front();
            check_field("accepted", want.accepted, got.accepted);
            check_field("evicted_valid", want.evicted_valid, got.evicted_valid);
            check_field("evicted_tag", want.evicted_tag, got.evicted_tag);
            check_field("entry_count", want.entry_count, got.entry_count);
            check_field("best_valid", want.best_valid, got.best_valid);
            check_field("best_tag", want.best_tag, got.best_tag);
            check_field("best_score", want.best_score, got.best_score);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    logic calm = 1'b0;
    int   cycle_count = 0;

    score_list_mirror tracker = new();

    tksl_in_if  req_ch();
    tksl_out_if rsp_ch();

    top_k_score_list_core #(.CAPACITY(LIST_DEPTH)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top_k_score_list_core: FAIL");
            $finish;
        end
    end

    // Result side: random back-pressure, none while calm
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 11);
    end

    always @(posedge clk)
    begin
        list_result_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.accepted      = rsp_ch.accepted;
            got.evicted_valid = rsp_ch.evicted_valid;
            got.evicted_tag   = rsp_ch.evicted_tag;
            got.entry_count   = rsp_ch.entry_count;
            got.best_valid    = rsp_ch.best_valid;
            got.best_tag      = rsp_ch.best_tag;
            got.best_score    = rsp_ch.best_score;
            tracker.compare_result(got);
        end
    end

    task automatic push_item(logic [OPC_W-1:0] op, score_t score, tag_t tag,
                             logic [SLOT_W-1:0] slot);
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.new_score  <= score;
        req_ch.new_tag    <= tag;
        req_ch.slot_index <= slot;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        tracker.apply_request(op, score, tag, slot);
        if (!calm && $urandom_range(0, 99) < 11)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic push_random();
        int                pick;
        int                v;
        logic [OPC_W-1:0]  op;
        score_t            score;
        logic [SLOT_W-1:0] slot;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            op = OP_CLEAR;
        else if (pick < 15)
            op = OP_OVERWRITE;
        else if (pick < 17)
            op = OP_RESERVED;
        else
            op = OP_INSERT;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            // narrow range so ties are frequent
            v = $urandom_range(0, 8);
            score = score_t'((v - 4) * 65536);
        end
        else if (pick < 50)
            score = tracker.floor_score;
        else if (pick < 55)
            score = pick[0] ? SCORE_MIN : 32'sh7FFF_FFFF;
        else
            score = $urandom;
        if ($urandom_range(0, 3) == 0)
            slot = SLOT_W'($urandom);
        else
            slot = SLOT_W'($urandom_range(0, tracker.held_count));
        push_item(op, score, tag_t'($urandom), slot);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    task automatic write_mode(logic mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.sorted = mode;
    endtask

    initial
    begin
        int   k;
        int   v;
        int   p;
        logic phase_mode[5];
        phase_mode = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= OP_INSERT;
        req_ch.new_score  <= '0;
        req_ch.new_tag    <= '0;
        req_ch.slot_index <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: sorted mode out of reset
        push_item(OP_INSERT, SCORE_MIN, 16'hFFFF, 4'd0);
        push_item(OP_OVERWRITE, 32'sh7FFF_FFFF, 16'h0000, 4'd0);
        push_item(OP_OVERWRITE, 32'sh0000_0000, 16'h1234, 4'd15);
        push_item(OP_RESERVED, 32'sh1234_5678, 16'h4321, 4'd0);
        push_item(OP_INSERT, 32'sh7FFF_FFFF, 16'h0001, 4'd0);
        for (k = 0; k < 14; k++)
        begin
            v = $urandom_range(0, 6);
            push_item(OP_INSERT, score_t'((v - 3) * 65536), tag_t'(k + 2), SLOT_W'(k));
        end
        // list is full now: below floor, at floor, above everything
        push_item(OP_INSERT, tracker.floor_score - 1, 16'h7777, 4'd0);
        push_item(OP_INSERT, tracker.floor_score, 16'hAAAA, 4'd0);
        push_item(OP_INSERT, 32'sh7FFF_FFFF, 16'h5555, 4'hF);
        push_item(OP_OVERWRITE, SCORE_MIN, 16'hBEEF, 4'd15);
        push_item(OP_CLEAR, 32'sh0000_0000, 16'h0000, 4'd0);

        // Random phases, mode changed only while idle
        for (p = 0; p < 5; p++)
        begin
            wait_idle();
            write_mode(phase_mode[p]);
            calm <= (p == 2);
            for (k = 0; k < PHASE_ITEMS; k++)
                push_random();
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (tracker.errors == 0)
            $display("tb_top_k_score_list_core: PASS");
        else
            $display("tb_top_k_score_list_core: FAIL");
        $finish;
    end

endmodule
